/* rtl/wpma_pkg.sv */
// Shared types and constants of the weighted point moment accumulator.
package wpma_pkg;

  localparam int unsigned A_W       = 68;
  localparam int unsigned B_W       = 59;
  localparam int unsigned DV_W      = 41;
  localparam int unsigned RES_W     = 102;
  localparam int unsigned LO_W      = 34;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned MUL_STEPS = 34;
  localparam int unsigned DIV_STEPS = 59;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [23:0] MIN_WEIGHT_RESET = 24'd6554;

  localparam logic [1:0] ROW_IDX [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] COL_IDX [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef struct packed {
    logic start;
    logic op;
  } wpma_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wpma_sts_t;

endpackage

/* rtl/wpma_if.sv */
// Request, result and configuration channels of the weighted point moment accumulator.
interface wpma_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        [23:0] weight;
  modport source (output valid, func, point_x, point_y, point_z, normal_x, normal_y,
                  normal_z, weight, input ready);
  modport sink (input valid, func, point_x, point_y, point_z, normal_x, normal_y,
                normal_z, weight, output ready);
endinterface

interface wpma_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_x;
  logic signed [31:0] mean_y;
  logic signed [31:0] mean_z;
  logic signed [63:0] scatter_xx;
  logic signed [63:0] scatter_xy;
  logic signed [63:0] scatter_xz;
  logic signed [63:0] scatter_yy;
  logic signed [63:0] scatter_yz;
  logic signed [63:0] scatter_zz;
  logic signed [15:0] avg_normal_x;
  logic signed [15:0] avg_normal_y;
  logic signed [15:0] avg_normal_z;
  modport source (output valid, mean_x, mean_y, mean_z, scatter_xx, scatter_xy,
                  scatter_xz, scatter_yy, scatter_yz, scatter_zz, avg_normal_x,
                  avg_normal_y, avg_normal_z, input ready);
  modport sink (input valid, mean_x, mean_y, mean_z, scatter_xx, scatter_xy,
                scatter_xz, scatter_yy, scatter_yz, scatter_zz, avg_normal_x,
                avg_normal_y, avg_normal_z, output ready);
endinterface

interface wpma_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/wpma_unit.sv */
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module wpma_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wpma_pkg::wpma_req_t            req,
  input  logic [wpma_pkg::A_W-1:0]       a,
  input  logic [wpma_pkg::B_W-1:0]       b,
  input  logic [wpma_pkg::DV_W-1:0]      dv,
  output wpma_pkg::wpma_sts_t            sts,
  output logic [wpma_pkg::RES_W-1:0]     res
);
  import wpma_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic             op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [A_W-1:0]   a_r;
  logic [A_W-1:0]   hi_r;
  logic [LO_W-1:0]  lo_r;
  logic [B_W-1:0]   num_r;
  logic [DV_W-1:0]  rem_r;
  logic [DV_W-1:0]  div_r;
  logic [A_W:0]     mul_sum;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    trial_sub;
  logic             ge;

  assign mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign trial     = {rem_r, num_r[B_W-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign ge        = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= (req.op == OP_DIV) ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= a;
      hi_r  <= '0;
      lo_r  <= b[LO_W-1:0];
      num_r <= b;
      rem_r <= '0;
      div_r <= dv;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        {hi_r, lo_r} <= {mul_sum, lo_r[LO_W-1:1]};
      end else begin
        rem_r <= ge ? trial_sub[DV_W-1:0] : trial[DV_W-1:0];
        num_r <= {num_r[B_W-2:0], ge};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res = (op_r == OP_MUL) ? {hi_r, lo_r} : {(RES_W - B_W)'(0), num_r};

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("unit started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("done without a finished run");
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("step count left over");

endmodule

/* rtl/weighted_point_moment_accumulator.sv */
// Top level: sequencer and moment stores of the weighted point moment accumulator.
// The input channel in_if takes one request per item: func 1 clears all moments,
// func 0 offers a weighted point with its normal. A point whose weight is at or
// below min_weight leaves the moments unchanged. Each request returns exactly
// one result on out_if with the moments after the update.
// The cfg_if channel writes min_weight; it is always ready. The user must write it
// only while idle; the block itself does not enforce this. A point is worked
// through one shared unit that multiplies or divides one bit per cycle.
// An integrated point needs three mean steps, six scatter terms and three normal
// steps. A clear or an ignored point goes straight to the output phase, which
// loads the result register once it is free. in_if.ready is high only while the
// sequencer is idle, so one request is in work at a time, and a new request is
// accepted only once the previous result has been loaded into the output register.
// The result sits in an output register; a new request is accepted while it
// waits, and its own result is held back until the earlier one is taken.
// Synchronous reset zeroes all moments and sets min_weight to 6554.
module weighted_point_moment_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  wpma_in_if.sink     in_if,
  wpma_out_if.source  out_if,
  wpma_cfg_if.sink    cfg_if
);
  import wpma_pkg::*;

  localparam logic [3:0] P_IDLE  = 4'd0;
  localparam logic [3:0] P_WT    = 4'd1;
  localparam logic [3:0] P_MMUL  = 4'd2;
  localparam logic [3:0] P_MDIV  = 4'd3;
  localparam logic [3:0] P_SMUL1 = 4'd4;
  localparam logic [3:0] P_SMUL2 = 4'd5;
  localparam logic [3:0] P_NMUL  = 4'd6;
  localparam logic [3:0] P_NDIV  = 4'd7;
  localparam logic [3:0] P_OUT   = 4'd8;

  logic [3:0]         phase_r;
  logic               wait_r;
  logic [2:0]         idx_r;
  logic [23:0]        min_weight_r;
  logic [39:0]        tw_r;
  logic signed [31:0] mean_r [3];
  logic signed [63:0] sc_r [6];
  logic signed [15:0] nrm_r [3];
  logic signed [32:0] d_r [3];
  logic signed [32:0] e_r [3];
  logic signed [31:0] pt_r [3];
  logic signed [15:0] nin_r [3];
  logic [23:0]        w_r;
  logic [A_W-1:0]     tmp_r;
  logic               out_valid_r;

  wpma_req_t          req;
  wpma_sts_t          sts;
  logic [A_W-1:0]     u_a;
  logic [B_W-1:0]     u_b;
  logic [DV_W-1:0]    u_dv;
  logic [RES_W-1:0]   u_res;

  logic [1:0]         i2;
  logic               norm_ph;
  logic signed [32:0] diff_c;
  logic [32:0]        mag_c;
  logic [32:0]        step_c;
  logic signed [31:0] m_new;
  logic signed [15:0] n_new;
  logic signed [32:0] e_c;
  logic signed [32:0] sd;
  logic signed [32:0] se;
  logic [32:0]        mag_d;
  logic [32:0]        mag_e;
  logic               sc_neg;
  logic [58:0]        term_mag;
  logic [63:0]        term;
  logic [63:0]        sc_old;
  logic [63:0]        sc_sum;
  logic [63:0]        sc_sat;
  logic [40:0]        tw_sum;
  logic               working;
  logic               in_acc;
  logic               unit_done;
  logic               out_load;

  assign i2      = idx_r[1:0];
  assign norm_ph = (phase_r == P_NMUL) || (phase_r == P_NDIV);
  assign in_acc  = in_if.valid && in_if.ready;
  assign unit_done = wait_r && sts.done;
  assign out_load  = (phase_r == P_OUT) && (!out_valid_r || out_if.ready);

  always_comb begin
    if (norm_ph) begin
      diff_c = {{17{nin_r[i2][15]}}, nin_r[i2]} - {{17{nrm_r[i2][15]}}, nrm_r[i2]};
    end else begin
      diff_c = {pt_r[i2][31], pt_r[i2]} - {mean_r[i2][31], mean_r[i2]};
    end
    mag_c  = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
    step_c = diff_c[32] ? (33'd0 - u_res[32:0]) : u_res[32:0];
    m_new  = mean_r[i2] + step_c[31:0];
    n_new  = nrm_r[i2] + step_c[15:0];
    e_c    = {pt_r[i2][31], pt_r[i2]} - {m_new[31], m_new};
  end

  always_comb begin
    sd       = d_r[ROW_IDX[idx_r]];
    se       = e_r[COL_IDX[idx_r]];
    mag_d    = sd[32] ? 33'(-sd) : 33'(sd);
    mag_e    = se[32] ? 33'(-se) : 33'(se);
    sc_neg   = sd[32] ^ se[32];
    term_mag = {1'b0, u_res[89:32]} + {58'd0, u_res[31]};
    term     = sc_neg ? (64'd0 - {5'd0, term_mag}) : {5'd0, term_mag};
    sc_old   = sc_r[idx_r];
    sc_sum   = sc_old + term;
    if ((sc_old[63] == term[63]) && (sc_sum[63] != sc_old[63])) begin
      sc_sat = sc_old[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sc_sat = sc_sum;
    end
  end

  assign tw_sum = {1'b0, tw_r} + {17'd0, w_r};

  always_comb begin
    working = 1'b1;
    req.op  = OP_MUL;
    u_a     = '0;
    u_b     = '0;
    u_dv    = {tw_r, 1'b0};
    case (phase_r)
      P_MMUL, P_NMUL: begin
        u_a = {35'd0, mag_c};
        u_b = {35'd0, w_r};
      end
      P_MDIV, P_NDIV: begin
        req.op = OP_DIV;
        u_b    = {tmp_r[57:0], 1'b0} + {19'd0, tw_r};
      end
      P_SMUL1: begin
        u_a = {35'd0, mag_d};
        u_b = {26'd0, mag_e};
      end
      P_SMUL2: begin
        u_a = tmp_r;
        u_b = {35'd0, w_r};
      end
      default: working = 1'b0;
    endcase
    req.start = working && !wait_r;
  end

  wpma_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (u_a),
    .b     (u_b),
    .dv    (u_dv),
    .sts   (sts),
    .res   (u_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= P_IDLE;
      wait_r       <= 1'b0;
      idx_r        <= '0;
      min_weight_r <= MIN_WEIGHT_RESET;
      tw_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        mean_r[k] <= '0;
        nrm_r[k]  <= '0;
      end
      for (int k = 0; k < 6; k++) begin
        sc_r[k] <= '0;
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        min_weight_r <= cfg_if.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (req.start) begin
        wait_r <= 1'b1;
      end else if (unit_done) begin
        wait_r <= 1'b0;
      end
      case (phase_r)
        P_IDLE: begin
          if (in_acc) begin
            idx_r <= '0;
            if (in_if.func == FUNC_CLEAR) begin
              tw_r <= '0;
              for (int k = 0; k < 3; k++) begin
                mean_r[k] <= '0;
                nrm_r[k]  <= '0;
              end
              for (int k = 0; k < 6; k++) begin
                sc_r[k] <= '0;
              end
              phase_r <= P_OUT;
            end else if (in_if.weight > min_weight_r) begin
              phase_r <= P_WT;
            end else begin
              phase_r <= P_OUT;
            end
          end
        end
        P_WT: begin
          tw_r    <= tw_sum[40] ? {40{1'b1}} : tw_sum[39:0];
          phase_r <= P_MMUL;
        end
        P_MMUL: begin
          if (unit_done) phase_r <= P_MDIV;
        end
        P_MDIV: begin
          if (unit_done) begin
            mean_r[i2] <= m_new;
            d_r[i2]    <= diff_c;
            e_r[i2]    <= e_c;
            if (idx_r == 3'd2) begin
              idx_r   <= '0;
              phase_r <= P_SMUL1;
            end else begin
              idx_r   <= idx_r + 1'b1;
              phase_r <= P_MMUL;
            end
          end
        end
        P_SMUL1: begin
          if (unit_done) phase_r <= P_SMUL2;
        end
        P_SMUL2: begin
          if (unit_done) begin
            sc_r[idx_r] <= sc_sat;
            if (idx_r == 3'd5) begin
              idx_r   <= '0;
              phase_r <= P_NMUL;
            end else begin
              idx_r   <= idx_r + 1'b1;
              phase_r <= P_SMUL1;
            end
          end
        end
        P_NMUL: begin
          if (unit_done) phase_r <= P_NDIV;
        end
        P_NDIV: begin
          if (unit_done) begin
            nrm_r[i2] <= n_new;
            if (idx_r == 3'd2) begin
              idx_r   <= '0;
              phase_r <= P_OUT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              phase_r <= P_NMUL;
            end
          end
        end
        P_OUT: begin
          if (out_load) begin
            phase_r <= P_IDLE;
          end
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_r[0]  <= in_if.point_x;
      pt_r[1]  <= in_if.point_y;
      pt_r[2]  <= in_if.point_z;
      nin_r[0] <= in_if.normal_x;
      nin_r[1] <= in_if.normal_y;
      nin_r[2] <= in_if.normal_z;
      w_r      <= in_if.weight;
    end
    if (unit_done && ((phase_r == P_MMUL) || (phase_r == P_SMUL1) ||
                      (phase_r == P_SMUL2) || (phase_r == P_NMUL))) begin
      tmp_r <= u_res[A_W-1:0];
    end
    if (out_load) begin
      out_if.mean_x       <= mean_r[0];
      out_if.mean_y       <= mean_r[1];
      out_if.mean_z       <= mean_r[2];
      out_if.scatter_xx   <= sc_r[0];
      out_if.scatter_xy   <= sc_r[1];
      out_if.scatter_xz   <= sc_r[2];
      out_if.scatter_yy   <= sc_r[3];
      out_if.scatter_yz   <= sc_r[4];
      out_if.scatter_zz   <= sc_r[5];
      out_if.avg_normal_x <= nrm_r[0];
      out_if.avg_normal_y <= nrm_r[1];
      out_if.avg_normal_z <= nrm_r[2];
    end
  end

  assign in_if.ready  = (phase_r == P_IDLE);
  assign out_if.valid = out_valid_r;
  assign cfg_if.ready = 1'b1;

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> wait_r) else $error("unit result with no request outstanding");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_IDLE) |-> !wait_r && !sts.busy) else $error("unit busy while idle");
  a_weight_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != P_IDLE) && (phase_r != P_WT) |=> tw_r == $past(tw_r))
    else $error("total weight changed outside its update");

endmodule

/* tb/wpma_tb_pkg.sv */
// Request and result types of the weighted point moment accumulator testbench.
package wpma_tb_pkg;

  typedef struct {
    logic               func;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic        [23:0] weight;
  } point_req_t;

  typedef struct {
    logic signed [31:0] mean [3];
    logic signed [63:0] scatter [6];
    logic signed [15:0] normal [3];
  } moments_t;

endpackage

/* tb/testbench.sv */
// Testbench of the weighted point moment accumulator: directed table, random points, predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wpma_pkg::*;
  import wpma_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;
  int   pending = 0;

  wpma_in_if  in_if ();
  wpma_out_if out_if ();
  wpma_cfg_if cfg_if ();

  weighted_point_moment_accumulator u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic        [23:0]  min_weight_q;
  logic        [39:0]  total_weight_q;
  logic signed [63:0]  mean_q [3];
  logic signed [63:0]  scatter_q [6];
  logic signed [63:0]  normal_q [3];
  moments_t            moments_q [$];

  function automatic logic signed [63:0] step_toward(logic [23:0] w, logic signed [63:0] diff,
                                                     logic [39:0] wt);
    logic [127:0] mag, q;
    mag = diff < 0 ? -diff : diff;
    q = (2 * (mag * w) + wt) / (2 * {88'd0, wt});
    return diff < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [63:0] cross_term(logic [23:0] w, logic signed [63:0] d,
                                                    logic signed [63:0] e);
    logic [127:0] a, b, prod;
    logic [63:0]  mag;
    a = d < 0 ? -d : d;
    b = e < 0 ? -e : e;
    prod = (a * b * w) + 128'h8000_0000;
    mag = prod[95:32];
    return ((d < 0) != (e < 0)) ? -mag : mag;
  endfunction

  function automatic logic signed [63:0] add_clamped(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic moments_t predict_moments(point_req_t r);
    moments_t m;
    logic signed [63:0] p [3], d [3], e [3], nm [3];
    logic [40:0] wsum;
    p = '{r.px, r.py, r.pz};
    nm = '{r.nx, r.ny, r.nz};
    if (r.func == FUNC_CLEAR) begin
      total_weight_q = '0;
      mean_q = '{0, 0, 0};
      normal_q = '{0, 0, 0};
      scatter_q = '{0, 0, 0, 0, 0, 0};
    end else if (r.weight > min_weight_q) begin
      wsum = total_weight_q + r.weight;
      total_weight_q = wsum[40] ? 40'hFF_FFFF_FFFF : wsum[39:0];
      for (int i = 0; i < 3; i++) begin
        d[i] = p[i] - mean_q[i];
        mean_q[i] += step_toward(r.weight, d[i], total_weight_q);
        e[i] = p[i] - mean_q[i];
      end
      for (int k = 0; k < 6; k++)
        scatter_q[k] = add_clamped(scatter_q[k],
                                   cross_term(r.weight, d[ROW_IDX[k]], e[COL_IDX[k]]));
      for (int i = 0; i < 3; i++)
        normal_q[i] += step_toward(r.weight, nm[i] - normal_q[i], total_weight_q);
    end
    for (int i = 0; i < 3; i++) begin
      m.mean[i] = mean_q[i][31:0];
      m.normal[i] = normal_q[i][15:0];
    end
    for (int k = 0; k < 6; k++) m.scatter[k] = scatter_q[k];
    return m;
  endfunction

  task automatic send_point(point_req_t r, bit has_fixed, moments_t fixed);
    moments_t m;
    int       idle;
    idle = $urandom_range(0, 11);
    if (idle != 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func <= r.func;
    in_if.point_x <= r.px;
    in_if.point_y <= r.py;
    in_if.point_z <= r.pz;
    in_if.normal_x <= r.nx;
    in_if.normal_y <= r.ny;
    in_if.normal_z <= r.nz;
    in_if.weight <= r.weight;
    do @(posedge clk); while (!in_if.ready);
    m = predict_moments(r);
    if (has_fixed) m = fixed;
    moments_q.push_back(m);
    pending++;
  endtask

  task automatic write_min_weight(logic [23:0] v);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    min_weight_q = v;
  endtask

  function automatic point_req_t rand_point(int mode);
    point_req_t r;
    r.func = ($urandom_range(0, 39) == 0);
    r.px = $urandom;
    r.py = $urandom;
    r.pz = $urandom;
    if (mode == 0) begin
      r.px = $signed(r.px) >>> $urandom_range(4, 20);
      r.py = $signed(r.py) >>> $urandom_range(4, 20);
      r.pz = $signed(r.pz) >>> $urandom_range(4, 20);
    end
    r.nx = $urandom;
    r.ny = $urandom;
    r.nz = $urandom;
    r.weight = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h4_0000));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      moments_t x, a;
      a.mean = '{out_if.mean_x, out_if.mean_y, out_if.mean_z};
      a.scatter = '{out_if.scatter_xx, out_if.scatter_xy, out_if.scatter_xz,
                    out_if.scatter_yy, out_if.scatter_yz, out_if.scatter_zz};
      a.normal = '{out_if.avg_normal_x, out_if.avg_normal_y, out_if.avg_normal_z};
      if (moments_q.size() == 0) begin
        $display("%0t unexpected result", $time);
        failed = 1'b1;
      end else begin
        x = moments_q.pop_front();
        pending--;
        for (int i = 0; i < 3; i++) begin
          if (a.mean[i] !== x.mean[i]) begin
            $display("%0t mean[%0d] exp %h got %h", $time, i, x.mean[i], a.mean[i]);
            failed = 1'b1;
          end
          if (a.normal[i] !== x.normal[i]) begin
            $display("%0t normal[%0d] exp %h got %h", $time, i, x.normal[i], a.normal[i]);
            failed = 1'b1;
          end
        end
        for (int k = 0; k < 6; k++)
          if (a.scatter[k] !== x.scatter[k]) begin
            $display("%0t scatter[%0d] exp %h got %h", $time, k, x.scatter[k], a.scatter[k]);
            failed = 1'b1;
          end
      end
    end
  end

  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      gap = $urandom_range(0, 11);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_if.valid));
    end
  end

  initial begin
    #100_000_000;
    $display("weighted_point_moment_accumulator verification failed");
    $finish;
  end

  initial begin
    point_req_t table_q [$];
    bit         fixed_q [$];
    point_req_t r;
    moments_t   zero_m, none_m;
    int         lim;
    in_if.valid = 1'b0;
    in_if.func = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    in_if.normal_x = '0;
    in_if.normal_y = '0;
    in_if.normal_z = '0;
    in_if.weight = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    zero_m.mean = '{0, 0, 0};
    zero_m.normal = '{0, 0, 0};
    zero_m.scatter = '{0, 0, 0, 0, 0, 0};
    none_m = zero_m;
    min_weight_q = MIN_WEIGHT_RESET;
    total_weight_q = '0;
    mean_q = '{0, 0, 0};
    normal_q = '{0, 0, 0};
    scatter_q = '{0, 0, 0, 0, 0, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    table_q = '{
      '{1'b0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 24'd6554},
      '{1'b0, 32'sd65536, -32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 24'd6555},
      '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
        24'hFF_FFFF},
      '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -16'sh8000, 16'sh7FFF, -16'sh8000,
        24'hFF_FFFF},
      '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        24'h01_0000},
      '{1'b0, 32'sd3, -32'sd3, 32'sd1, 16'sd1, -16'sd1, 16'sd3, 24'd6553},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1, -16'sd1, -16'sd1,
        24'hFF_FFFF},
      '{1'b0, 32'sd131072, 32'sd196608, -32'sd65536, 16'sd0, 16'sd16384, 16'sd0, 24'd32768},
      '{1'b0, -32'sd131072, 32'sd0, 32'sd65536, 16'sd0, 16'sd0, 16'sd16384, 24'd98304},
      '{1'b1, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 24'd0}
    };
    fixed_q = '{1, 0, 0, 0, 0, 0, 1, 0, 0, 1};
    foreach (table_q[i]) send_point(table_q[i], fixed_q[i], zero_m);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_min_weight(24'd0);
        1: write_min_weight(24'hFF_FFFF);
        2: write_min_weight(24'($urandom_range(0, 24'h2_0000)));
        default: write_min_weight(MIN_WEIGHT_RESET);
      endcase
      lim = (phase == 1) ? 30 : 320;
      for (int n = 0; n < lim; n++) begin
        r = rand_point(($urandom_range(0, 4) == 0) ? 1 : 0);
        send_point(r, 1'b0, none_m);
      end
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("weighted_point_moment_accumulator verification clean");
    end else begin
      $display("weighted_point_moment_accumulator verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/wpma_pkg.sv
rtl/wpma_if.sv
rtl/wpma_unit.sv
rtl/weighted_point_moment_accumulator.sv
tb/wpma_tb_pkg.sv
tb/testbench.sv
